@@ hdl/aoi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared constants for the area-of-interest tracker: field widths, request
// and event codes, and default sizes. No dependencies.

package aoi_pkg;

  localparam int ID_BITS         = 16;
  localparam int RAD_BITS        = 15;
  localparam int IN_COORD_BITS   = 16;
  localparam int MAX_OBJECTS_DEF = 16;
  localparam int COORD_BITS_DEF  = 16;

  // Events beyond this count for one request are dropped.
  localparam int RESULT_CAP = 30;
  localparam int EMIT_W     = $clog2(RESULT_CAP + 1);

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_MOVE   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [2:0] EV_ENTER   = 3'd0;
  localparam logic [2:0] EV_LEAVE   = 3'd1;
  localparam logic [2:0] EV_MOVE    = 3'd2;
  localparam logic [2:0] EV_NONE    = 3'd3;
  localparam logic [2:0] EV_IGNORED = 3'd4;

endpackage

`default_nettype wire

@@ hdl/aoi_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Object table storage: one write port and one read port with registered
// read data. Depends on aoi_pkg for default widths.

module aoi_table #(
  parameter int DEPTH  = aoi_pkg::MAX_OBJECTS_DEF,
  parameter int DATA_W = aoi_pkg::ID_BITS + 2 * aoi_pkg::COORD_BITS_DEF + aoi_pkg::RAD_BITS,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ hdl/aoi_square.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared square test: is a point within radius of a center on both axes,
// edges included. Depends on aoi_pkg for the radius width.

module aoi_square #(
  parameter int COORD_BITS = aoi_pkg::COORD_BITS_DEF
) (
  input  wire logic signed [COORD_BITS-1:0]       px,
  input  wire logic signed [COORD_BITS-1:0]       py,
  input  wire logic signed [COORD_BITS-1:0]       cx,
  input  wire logic signed [COORD_BITS-1:0]       cy,
  input  wire logic        [aoi_pkg::RAD_BITS-1:0] radius,
  output logic                                    in_sq
);

  localparam int CMP_W = (COORD_BITS + 1 > aoi_pkg::RAD_BITS) ?
                         COORD_BITS + 1 : aoi_pkg::RAD_BITS;

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic        [COORD_BITS:0] ax;
  logic        [COORD_BITS:0] ay;
  logic        [CMP_W-1:0]    ax_ext;
  logic        [CMP_W-1:0]    ay_ext;
  logic        [CMP_W-1:0]    r_ext;

  always_comb begin
    dx     = {px[COORD_BITS-1], px} - {cx[COORD_BITS-1], cx};
    dy     = {py[COORD_BITS-1], py} - {cy[COORD_BITS-1], cy};
    ax     = dx[COORD_BITS] ? unsigned'(-dx) : unsigned'(dx);
    ay     = dy[COORD_BITS] ? unsigned'(-dy) : unsigned'(dy);
    ax_ext = CMP_W'(ax);
    ay_ext = CMP_W'(ay);
    r_ext  = CMP_W'(radius);
    in_sq  = (ax_ext <= r_ext) && (ay_ext <= r_ext);
  end

endmodule

`default_nettype wire

@@ hdl/area_of_interest_tracker_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Area-of-interest tracker top level: request sequencer, slot valid bits and
// event output register. Uses aoi_pkg, aoi_table and aoi_square.
//
//   channel   direction   handshake              payload
//   request   in          in_valid / in_stall    operation, object_id, pos_x,
//                                                pos_y, view_radius
//   event     out         out_valid / out_stall  event_kind, neighbour_id, last
//
// A request first scans the table for its id and the lowest free slot (read
// data is registered, so it lags the address), then passes a decide state,
// then one square-test pass per center through the shared comparator (one
// pass for add and remove, two for move), then a write state. Events are
// found by walking the slots once per event group; each event found then
// passes a read state and an output state, where it holds while out_stall is
// high. After the last event transfer the block returns to idle and can take
// the next request. Reset clears all valid bits at once, with no sweep.
// in_stall stays high from the request transfer until its last event is
// taken; a stalled event holds on the outputs.

module area_of_interest_tracker_unit #(
  parameter int MAX_OBJECTS = aoi_pkg::MAX_OBJECTS_DEF,
  parameter int COORD_BITS  = aoi_pkg::COORD_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic        [1:0]                     operation,
  input  wire logic        [aoi_pkg::ID_BITS-1:0]    object_id,
  input  wire logic signed [aoi_pkg::IN_COORD_BITS-1:0] pos_x,
  input  wire logic signed [aoi_pkg::IN_COORD_BITS-1:0] pos_y,
  input  wire logic        [aoi_pkg::RAD_BITS-1:0]   view_radius,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic             [2:0]                     event_kind,
  output logic             [aoi_pkg::ID_BITS-1:0]    neighbour_id,
  output logic                                       last
);

  localparam int SLOT_W  = $clog2(MAX_OBJECTS);
  localparam int CNT_W   = $clog2(MAX_OBJECTS + 1);
  localparam int ID_B    = aoi_pkg::ID_BITS;
  localparam int RAD_B   = aoi_pkg::RAD_BITS;
  localparam int ENTRY_W = ID_B + 2 * COORD_BITS + RAD_B;
  localparam int EMIT_W  = aoi_pkg::EMIT_W;
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_OBJECTS);

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_DECIDE, S_SCAN, S_WRITE, S_EM_SCAN, S_EM_RD, S_OUT
  } state_t;

  state_t state;

  // Latched request.
  logic        [1:0]            op_q;
  logic        [ID_B-1:0]       id_q;
  logic signed [COORD_BITS-1:0] nx_q;
  logic signed [COORD_BITS-1:0] ny_q;
  logic        [RAD_B-1:0]      rad_q;

  // Scan control.
  logic [CNT_W-1:0]  cnt;
  logic              rd_pend;
  logic [SLOT_W-1:0] rd_idx;
  logic              pass_new;
  logic [1:0]        grp;

  // Search results.
  logic                  self_found;
  logic [SLOT_W-1:0]     self_idx;
  logic signed [COORD_BITS-1:0] self_x;
  logic signed [COORD_BITS-1:0] self_y;
  logic [RAD_B-1:0]      self_r;
  logic                  free_found;
  logic [SLOT_W-1:0]     free_idx;

  // Current square center for the comparator.
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic [RAD_B-1:0]             cr;

  logic [MAX_OBJECTS-1:0] slot_valid;
  logic [MAX_OBJECTS-1:0] was_in;
  logic [MAX_OBJECTS-1:0] now_in;
  logic [CNT_W-1:0]       ev_total;
  logic [EMIT_W-1:0]      emitted;

  // Table ports.
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [SLOT_W-1:0] rd_addr;
  logic [ENTRY_W-1:0] rd_data;

  logic [ID_B-1:0]              rd_ident;
  logic signed [COORD_BITS-1:0] rd_x;
  logic signed [COORD_BITS-1:0] rd_y;
  logic [RAD_B-1:0]             rd_r;

  logic signed [31:0]           px_ext;
  logic signed [31:0]           py_ext;
  logic signed [COORD_BITS-1:0] in_x;
  logic signed [COORD_BITS-1:0] in_y;

  logic              in_sq;
  logic              other;
  logic              hit;
  logic              grp_bit;
  logic [2:0]        grp_kind;
  logic [EMIT_W-1:0] cap_total;
  logic              is_last;
  logic              cnt_done;
  logic              out_xfer;

  // Input coordinates are read as two's complement in their low COORD_BITS bits.
  assign px_ext = {{(32 - aoi_pkg::IN_COORD_BITS){pos_x[aoi_pkg::IN_COORD_BITS-1]}}, pos_x};
  assign py_ext = {{(32 - aoi_pkg::IN_COORD_BITS){pos_y[aoi_pkg::IN_COORD_BITS-1]}}, pos_y};
  assign in_x   = px_ext[COORD_BITS-1:0];
  assign in_y   = py_ext[COORD_BITS-1:0];

  assign rd_ident = rd_data[ENTRY_W-1 -: ID_B];
  assign rd_x     = rd_data[RAD_B + 2 * COORD_BITS - 1 -: COORD_BITS];
  assign rd_y     = rd_data[RAD_B + COORD_BITS - 1 -: COORD_BITS];
  assign rd_r     = rd_data[RAD_B-1:0];

  assign rd_addr  = cnt[SLOT_W-1:0];
  assign in_stall = (state != S_IDLE);
  assign cnt_done = (cnt == CNT_END);
  assign out_xfer = out_valid && !out_stall;

  aoi_table #(
    .DEPTH  (MAX_OBJECTS),
    .DATA_W (ENTRY_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  aoi_square #(
    .COORD_BITS (COORD_BITS)
  ) u_square (
    .px     (rd_x),
    .py     (rd_y),
    .cx     (cx),
    .cy     (cy),
    .radius (cr),
    .in_sq  (in_sq)
  );

  always_comb begin
    other = slot_valid[rd_idx] && !(self_found && (rd_idx == self_idx));
    hit   = other && in_sq;

    case (grp)
      2'd0:    grp_bit = now_in[rd_addr] && !was_in[rd_addr];
      2'd1:    grp_bit = was_in[rd_addr] && !now_in[rd_addr];
      2'd2:    grp_bit = was_in[rd_addr] && now_in[rd_addr];
      default: grp_bit = 1'b0;
    endcase

    case (grp)
      2'd0:    grp_kind = aoi_pkg::EV_ENTER;
      2'd1:    grp_kind = aoi_pkg::EV_LEAVE;
      default: grp_kind = aoi_pkg::EV_MOVE;
    endcase

    if (32'(ev_total) > aoi_pkg::RESULT_CAP) begin
      cap_total = EMIT_W'(aoi_pkg::RESULT_CAP);
    end else begin
      cap_total = EMIT_W'(ev_total);
    end
    is_last = (EMIT_W'(emitted + EMIT_W'(1)) == cap_total);

    // A move rewrites its own slot with the new position; the ident is the same.
    wr_en   = (state == S_WRITE) && ((op_q == aoi_pkg::OP_ADD) || (op_q == aoi_pkg::OP_MOVE));
    wr_addr = (op_q == aoi_pkg::OP_ADD) ? free_idx : self_idx;
    wr_data = {id_q, nx_q, ny_q, (op_q == aoi_pkg::OP_ADD) ? rad_q : self_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      slot_valid <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q       <= operation;
            id_q       <= object_id;
            nx_q       <= in_x;
            ny_q       <= in_y;
            rad_q      <= view_radius;
            cnt        <= '0;
            rd_pend    <= 1'b0;
            self_found <= 1'b0;
            free_found <= 1'b0;
            emitted    <= '0;
            state      <= S_SEARCH;
          end
        end

        // Read data is registered, so it arrives in the cycle after its slot counter value.
        S_SEARCH: begin
          if (!cnt_done) begin
            cnt <= cnt + CNT_W'(1);
          end
          rd_pend <= !cnt_done;
          rd_idx  <= rd_addr;
          if (rd_pend) begin
            if (slot_valid[rd_idx] && (rd_ident == id_q)) begin
              self_found <= 1'b1;
              self_idx   <= rd_idx;
              self_x     <= rd_x;
              self_y     <= rd_y;
              self_r     <= rd_r;
            end
            if (!slot_valid[rd_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
          end
          if (cnt_done && !rd_pend) begin
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          was_in   <= '0;
          now_in   <= '0;
          ev_total <= '0;
          cnt      <= '0;
          rd_pend  <= 1'b0;
          if ((op_q == aoi_pkg::OP_ADD) && !self_found && free_found) begin
            pass_new <= 1'b1;
            cx       <= nx_q;
            cy       <= ny_q;
            cr       <= rad_q;
            state    <= S_SCAN;
          end else if (((op_q == aoi_pkg::OP_MOVE) || (op_q == aoi_pkg::OP_REMOVE))
                       && self_found) begin
            pass_new <= 1'b0;
            cx       <= self_x;
            cy       <= self_y;
            cr       <= self_r;
            state    <= S_SCAN;
          end else begin
            out_valid    <= 1'b1;
            event_kind   <= aoi_pkg::EV_IGNORED;
            neighbour_id <= '0;
            last         <= 1'b1;
            state        <= S_OUT;
          end
        end

        // Old-center pass fills was_in, new-center pass fills now_in.
        // ev_total counts the union, which is the number of events.
        S_SCAN: begin
          if (!cnt_done) begin
            cnt <= cnt + CNT_W'(1);
          end
          rd_pend <= !cnt_done;
          rd_idx  <= rd_addr;
          if (rd_pend) begin
            if (pass_new) begin
              now_in[rd_idx] <= hit;
              if (hit && !was_in[rd_idx]) begin
                ev_total <= ev_total + CNT_W'(1);
              end
            end else begin
              was_in[rd_idx] <= hit;
              if (hit) begin
                ev_total <= ev_total + CNT_W'(1);
              end
            end
          end
          if (cnt_done && !rd_pend) begin
            if (!pass_new && (op_q == aoi_pkg::OP_MOVE)) begin
              pass_new <= 1'b1;
              cx       <= nx_q;
              cy       <= ny_q;
              cnt      <= '0;
            end else begin
              state <= S_WRITE;
            end
          end
        end

        S_WRITE: begin
          if (op_q == aoi_pkg::OP_ADD) begin
            slot_valid[free_idx] <= 1'b1;
          end else if (op_q == aoi_pkg::OP_REMOVE) begin
            slot_valid[self_idx] <= 1'b0;
          end
          cnt     <= '0;
          grp     <= 2'd0;
          emitted <= '0;
          if (cap_total == '0) begin
            out_valid    <= 1'b1;
            event_kind   <= aoi_pkg::EV_NONE;
            neighbour_id <= '0;
            last         <= 1'b1;
            state        <= S_OUT;
          end else begin
            state <= S_EM_SCAN;
          end
        end

        S_EM_SCAN: begin
          if (cnt_done) begin
            cnt <= '0;
            grp <= grp + 2'd1;
          end else if (grp_bit) begin
            state <= S_EM_RD;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end

        S_EM_RD: begin
          out_valid    <= 1'b1;
          event_kind   <= grp_kind;
          neighbour_id <= rd_ident;
          last         <= is_last;
          state        <= S_OUT;
        end

        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last) begin
              state <= S_IDLE;
            end else begin
              emitted <= emitted + EMIT_W'(1);
              cnt     <= cnt + CNT_W'(1);
              state   <= S_EM_SCAN;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // No new request is taken while an event is pending.
  a_busy_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request channel open while an event is pending");

  // The event count of one request stays within the cap.
  a_emit_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(emitted) < aoi_pkg::RESULT_CAP))
    else $error("event count exceeds cap");

  // After the final event transfer the block is ready again.
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && last) |=> !in_stall)
    else $error("block stays busy after final event");

  // The requesting object never appears among its own neighbours.
  a_no_self: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EM_SCAN) && self_found) |-> (!was_in[self_idx] && !now_in[self_idx]))
    else $error("object listed as its own neighbour");
`endif

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for area_of_interest_tracker_unit. It keeps a shadow
// object table to predict every event of each request: enter, leave, move, none and ignored.
// Depends on aoi_pkg and the tracker RTL only.

module tb_top;

  localparam int TABLE_SLOTS = aoi_pkg::MAX_OBJECTS_DEF;
  localparam int ID_W        = aoi_pkg::ID_BITS;
  localparam int XY_W        = aoi_pkg::IN_COORD_BITS;
  localparam int RAD_W       = aoi_pkg::RAD_BITS;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [2:0]      kind;
    logic [ID_W-1:0] nbr;
    logic            last;
  } aoi_event_t;

  typedef struct {
    logic [1:0]             op;
    logic [ID_W-1:0]        id;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [RAD_W-1:0]       rad;
  } aoi_req_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic [1:0]             operation;
  logic [ID_W-1:0]        object_id;
  logic signed [XY_W-1:0] pos_x;
  logic signed [XY_W-1:0] pos_y;
  logic [RAD_W-1:0]       view_radius;
  logic                   out_valid;
  logic                   out_stall;
  logic [2:0]             event_kind;
  logic [ID_W-1:0]        neighbour_id;
  logic                   last;

  area_of_interest_tracker_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .object_id    (object_id),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .view_radius  (view_radius),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_kind   (event_kind),
    .neighbour_id (neighbour_id),
    .last         (last)
  );

  // Shadow copy of the object table.
  bit              mirror_valid [TABLE_SLOTS];
  logic [ID_W-1:0] mirror_id    [TABLE_SLOTS];
  int              mirror_x     [TABLE_SLOTS];
  int              mirror_y     [TABLE_SLOTS];
  int              mirror_rad   [TABLE_SLOTS];

  aoi_event_t pending_events[$];
  aoi_event_t request_events[$];
  aoi_event_t want_ev;

  int fail_count   = 0;
  bit idle_en      = 1'b1;
  int holdoff_req  = 0;
  int holdoff_left = 0;
  int stall_burst  = 0;

  initial begin
    clk = 1'b0;
  end

  always #4 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic int find_object(input logic [ID_W-1:0] id);
    for (int k = 0; k < TABLE_SLOTS; k++) begin
      if (mirror_valid[k] && mirror_id[k] == id) return k;
    end
    return -1;
  endfunction

  function automatic bit in_square(input int k, input int cx, input int cy, input int r);
    int dx;
    int dy;
    dx = mirror_x[k] - cx;
    dy = mirror_y[k] - cy;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return (dx <= r) && (dy <= r);
  endfunction

  function automatic void add_event(input logic [2:0] kind, input logic [ID_W-1:0] nbr);
    aoi_event_t ev;
    if (request_events.size() < aoi_pkg::RESULT_CAP) begin
      ev.kind = kind;
      ev.nbr  = nbr;
      ev.last = 1'b0;
      request_events = {request_events, ev};
    end
  endfunction

  // Applies one accepted request to the shadow table and queues its events.
  function automatic void track_request(input aoi_req_t rq);
    int self;
    int slot;
    int cx;
    int cy;
    int r;
    int ox;
    int oy;
    bit was_in [TABLE_SLOTS];
    bit now_in [TABLE_SLOTS];
    bit other;
    aoi_event_t ev;
    request_events.delete();
    self = find_object(rq.id);
    cx = int'(rq.x);
    cy = int'(rq.y);
    if (rq.op == aoi_pkg::OP_ADD) begin
      slot = -1;
      if (self < 0) begin
        for (int k = 0; k < TABLE_SLOTS; k++) begin
          if (!mirror_valid[k] && slot < 0) slot = k;
        end
      end
      if (slot < 0) begin
        add_event(aoi_pkg::EV_IGNORED, '0);
      end else begin
        r = int'(rq.rad);
        mirror_valid[slot] = 1'b1;
        mirror_id[slot]    = rq.id;
        mirror_x[slot]     = cx;
        mirror_y[slot]     = cy;
        mirror_rad[slot]   = r;
        for (int k = 0; k < TABLE_SLOTS; k++) begin
          if (k != slot && mirror_valid[k] && in_square(k, cx, cy, r))
            add_event(aoi_pkg::EV_ENTER, mirror_id[k]);
        end
      end
    end else if (rq.op == aoi_pkg::OP_MOVE && self >= 0) begin
      ox = mirror_x[self];
      oy = mirror_y[self];
      r  = mirror_rad[self];
      for (int k = 0; k < TABLE_SLOTS; k++) begin
        other = (k != self) && mirror_valid[k];
        was_in[k] = other && in_square(k, ox, oy, r);
        now_in[k] = other && in_square(k, cx, cy, r);
      end
      mirror_x[self] = cx;
      mirror_y[self] = cy;
      for (int k = 0; k < TABLE_SLOTS; k++)
        if (now_in[k] && !was_in[k]) add_event(aoi_pkg::EV_ENTER, mirror_id[k]);
      for (int k = 0; k < TABLE_SLOTS; k++)
        if (was_in[k] && !now_in[k]) add_event(aoi_pkg::EV_LEAVE, mirror_id[k]);
      for (int k = 0; k < TABLE_SLOTS; k++)
        if (was_in[k] && now_in[k]) add_event(aoi_pkg::EV_MOVE, mirror_id[k]);
    end else if (rq.op == aoi_pkg::OP_REMOVE && self >= 0) begin
      ox = mirror_x[self];
      oy = mirror_y[self];
      r  = mirror_rad[self];
      for (int k = 0; k < TABLE_SLOTS; k++) begin
        if (k != self && mirror_valid[k] && in_square(k, ox, oy, r))
          add_event(aoi_pkg::EV_LEAVE, mirror_id[k]);
      end
      mirror_valid[self] = 1'b0;
    end else begin
      add_event(aoi_pkg::EV_IGNORED, '0);
    end
    if (request_events.size() == 0) add_event(aoi_pkg::EV_NONE, '0);
    ev = request_events.pop_back();
    ev.last = 1'b1;
    request_events = {request_events, ev};
    pending_events = {pending_events, request_events};
  endfunction

  // Holds the request until the transfer, then updates the prediction.
  task automatic send_request(input aoi_req_t rq);
    int gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    operation   <= rq.op;
    object_id   <= rq.id;
    pos_x       <= rq.x;
    pos_y       <= rq.y;
    view_radius <= rq.rad;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    track_request(rq);
  endtask

  task automatic send_fields(input logic [1:0] op, input logic [ID_W-1:0] id,
                             input int x, input int y, input int rad);
    aoi_req_t rq;
    rq.op  = op;
    rq.id  = id;
    rq.x   = XY_W'(x);
    rq.y   = XY_W'(y);
    rq.rad = RAD_W'(rad);
    send_request(rq);
  endtask

  task automatic sender_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    sender_idle();
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_live_slot();
    int live[$];
    for (int k = 0; k < TABLE_SLOTS; k++)
      if (mirror_valid[k]) live = {live, k};
    if (live.size() == 0) return -1;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int k = 0; k < TABLE_SLOTS; k++)
      if (mirror_valid[k]) n++;
    return n;
  endfunction

  // Most positions fall in one of three crowded regions so that squares overlap.
  function automatic int random_coord(input int region);
    int base;
    int off;
    if ($urandom_range(0, 99) < 15) return int'($urandom_range(0, 65535)) - 32768;
    case (region)
      0:       base = 0;
      1:       base = -32600;
      default: base = 32600;
    endcase
    off = $urandom_range(0, 400);
    return base + off - 200;
  endfunction

  function automatic aoi_req_t random_request();
    aoi_req_t rq;
    int live;
    int roll;
    int add_pct;
    int region;
    int k;
    int self;
    int r;
    int d;
    live = live_count();
    roll = $urandom_range(0, 99);
    region = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2);
    rq.x   = XY_W'(random_coord(region));
    rq.y   = XY_W'(random_coord(region));
    rq.rad = RAD_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 150)
                                                 : $urandom_range(0, 32767));
    rq.id  = ID_W'($urandom_range(0, 65535));
    if (live < 4) add_pct = 70;
    else if (live > 13) add_pct = 15;
    else add_pct = 40;
    if (roll < 8) begin
      // Requests that will mostly come back ignored.
      case ($urandom_range(0, 2))
        0: rq.op = OP_UNUSED;
        1: rq.op = ($urandom_range(0, 1) == 0) ? aoi_pkg::OP_MOVE : aoi_pkg::OP_REMOVE;
        default: begin
          rq.op = aoi_pkg::OP_ADD;
          k = pick_live_slot();
          if (k >= 0) rq.id = mirror_id[k];
        end
      endcase
      return rq;
    end
    if (live == 0 || $urandom_range(0, 99) < add_pct) begin
      rq.op = aoi_pkg::OP_ADD;
      while (find_object(rq.id) >= 0) rq.id = ID_W'($urandom_range(0, 65535));
    end else begin
      rq.op = ($urandom_range(0, 99) < 67) ? aoi_pkg::OP_MOVE : aoi_pkg::OP_REMOVE;
      rq.id = mirror_id[pick_live_slot()];
    end
    // Now and then land exactly on, or just past, the edge of a neighbour.
    if (rq.op != aoi_pkg::OP_REMOVE && live > 1 && $urandom_range(0, 5) == 0) begin
      self = find_object(rq.id);
      r = (rq.op == aoi_pkg::OP_MOVE) ? mirror_rad[self] : int'(rq.rad);
      k = pick_live_slot();
      if (k != self) begin
        d = r + int'($urandom_range(0, 1));
        if ($urandom_range(0, 1) == 0) d = -d;
        if ($urandom_range(0, 1) == 0) begin
          rq.x = XY_W'(mirror_x[k] + d);
          rq.y = XY_W'(mirror_y[k]);
        end else begin
          rq.x = XY_W'(mirror_x[k]);
          rq.y = XY_W'(mirror_y[k] + d);
        end
      end
    end
    return rq;
  endfunction

  // Receiver: random stall bursts, plus a long hold-off on request.
  always @(negedge clk) begin
    if (holdoff_req > 0) begin
      holdoff_left = holdoff_req;
      holdoff_req  = 0;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else if (stall_burst > 0) begin
      stall_burst--;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 11) == 0) begin
      stall_burst = $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_events.size() == 0) begin
        report_mismatch("event with nothing pending, kind", int'(event_kind), 0);
      end else begin
        want_ev = pending_events.pop_front();
        if (event_kind !== want_ev.kind)
          report_mismatch("event_kind", int'(event_kind), int'(want_ev.kind));
        if (neighbour_id !== want_ev.nbr)
          report_mismatch("neighbour_id", int'(neighbour_id), int'(want_ev.nbr));
        if (last !== want_ev.last)
          report_mismatch("last", int'(last), int'(want_ev.last));
      end
    end
  end

  task automatic test_unknown_and_unused();
    send_fields(aoi_pkg::OP_MOVE, 16'd5, 0, 0, 0);
    send_fields(aoi_pkg::OP_REMOVE, 16'd5, 0, 0, 0);
    send_fields(OP_UNUSED, 16'hFFFF, 32767, -32768, 32767);
  endtask

  task automatic test_extremes_and_duplicate();
    send_fields(aoi_pkg::OP_ADD, 16'h0000, -32768, -32768, 0);
    send_fields(aoi_pkg::OP_ADD, 16'hFFFF, 32767, 32767, 32767);
    send_fields(aoi_pkg::OP_ADD, 16'h1234, 0, 0, 32767);
    send_fields(aoi_pkg::OP_ADD, 16'h1234, 5, 5, 3);
  endtask

  // Object 10 moves so that one neighbour enters, one leaves and one stays.
  task automatic test_move_groups();
    send_fields(aoi_pkg::OP_ADD, 16'd10, 100, 100, 20);
    send_fields(aoi_pkg::OP_ADD, 16'd11, 120, 100, 5);
    send_fields(aoi_pkg::OP_ADD, 16'd12, 60, 100, 5);
    send_fields(aoi_pkg::OP_ADD, 16'd13, 100, 105, 5);
    send_fields(aoi_pkg::OP_MOVE, 16'd10, 80, 100, 0);
    send_fields(aoi_pkg::OP_MOVE, 16'd10, 80, 100, 32767);
    send_fields(aoi_pkg::OP_REMOVE, 16'd10, 0, 0, 0);
  endtask

  task automatic test_full_table();
    int i;
    i = 0;
    while (live_count() < TABLE_SLOTS) begin
      send_fields(aoi_pkg::OP_ADD, ID_W'(32'h0100 + i), -1000 + i * 3, 500, i * 7);
      i++;
    end
    send_fields(aoi_pkg::OP_ADD, 16'h0200, -1000, 500, 100);
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_request(random_request());
  endtask

  // The output is held off while requests keep arriving, so in_stall backs up.
  task automatic test_output_holdoff();
    holdoff_req = 400;
    repeat (10) send_request(random_request());
  endtask

  task automatic test_drain_pauses();
    repeat (2) begin
      wait_for_drain();
      repeat (5) send_request(random_request());
    end
  endtask

  task automatic test_no_idle_tail();
    idle_en = 1'b0;
    repeat (50) send_request(random_request());
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    out_stall   = 1'b0;
    operation   = aoi_pkg::OP_ADD;
    object_id   = '0;
    pos_x       = '0;
    pos_y       = '0;
    view_radius = '0;
    for (int k = 0; k < TABLE_SLOTS; k++) mirror_valid[k] = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_unknown_and_unused();
    test_extremes_and_duplicate();
    test_move_groups();
    test_full_table();
    test_random_traffic(200);
    test_output_holdoff();
    test_drain_pauses();
    test_no_idle_tail();

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ area_of_interest_tracker_unit.f @@
hdl/aoi_pkg.sv
hdl/aoi_table.sv
hdl/aoi_square.sv
hdl/area_of_interest_tracker_unit.sv
test/tb_top.sv
